// ===== rtl/dtp_pkg.sv =====
// Shared types, register codes and constants of the depth-to-point back-projector.
package dtp_pkg;

  localparam int DEPTH_W    = 16;
  localparam int COORD_W    = 12;
  localparam int CENTER_W   = 16;
  localparam int INV_W      = 24;
  localparam int INV_HALF_W = 12;
  localparam int POS_W      = 32;
  localparam int FRAC_SHIFT = 24;
  localparam int SUBPIX_W   = 4;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  localparam int DEFAULT_COORD_BITS = 12;
  localparam int DEFAULT_DEPTH_BITS = 16;

  localparam logic [DEPTH_W-1:0]  DEPTH_FLOOR_RESET = 16'd20;
  localparam logic [DEPTH_W-1:0]  DEPTH_CEIL_RESET  = 16'd4000;
  localparam logic [CENTER_W-1:0] CENTER_X_RESET    = 16'd4938;
  localparam logic [CENTER_W-1:0] CENTER_Y_RESET    = 16'd4011;
  localparam logic [INV_W-1:0]    INV_FOCAL_X_RESET = 24'd29313;
  localparam logic [INV_W-1:0]    INV_FOCAL_Y_RESET = 24'd29096;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DEPTH_FLOOR = 3'd0,
    REG_DEPTH_CEIL  = 3'd1,
    REG_CENTER_X    = 3'd2,
    REG_CENTER_Y    = 3'd3,
    REG_INV_FOCAL_X = 3'd4,
    REG_INV_FOCAL_Y = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth_mm;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
  } request_t;

  typedef struct packed {
    logic                    point_valid;
    logic signed [POS_W-1:0] x_pos;
    logic signed [POS_W-1:0] y_pos;
    logic [DEPTH_W-1:0]      z_pos;
  } result_t;

endpackage

// ===== rtl/depth_to_point_backproject.sv =====
// Pinhole back-projection of depth pixels into saturated fixed-point 3-D points.
//
// A request is taken at every clock edge where start is high and busy is low; busy is
// high only during reset, so one pixel enters per clock. Each result appears on result
// for one cycle with done high, in request order; the receiver cannot stall it. The
// five-stage multiply pipeline runs range test and offset, depth times offset, two
// half-width products with the reciprocal focal length, rounding add, saturation.
// Pixels outside the depth window or of zero depth give a result with point_valid low
// and all coordinates zero. Configuration must be written through cfg_write, cfg_index
// and cfg_data only while no request is in flight; the block itself does not enforce it.
module depth_to_point_backproject #(
  parameter int COORD_BITS = dtp_pkg::DEFAULT_COORD_BITS,
  parameter int DEPTH_BITS = dtp_pkg::DEFAULT_DEPTH_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  dtp_pkg::request_t                request,
  output logic                             done,
  output dtp_pkg::result_t                 result,
  input  logic                             cfg_write,
  input  logic [dtp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [dtp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CoordUse = (COORD_BITS < dtp_pkg::COORD_W) ? COORD_BITS : dtp_pkg::COORD_W;
  localparam int DepthUse = (DEPTH_BITS < dtp_pkg::DEPTH_W) ? DEPTH_BITS : dtp_pkg::DEPTH_W;
  localparam int PixW     = CoordUse + dtp_pkg::SUBPIX_W;
  localparam int MagW     = (PixW > dtp_pkg::CENTER_W) ? PixW : dtp_pkg::CENTER_W;
  localparam int ProdW    = DepthUse + MagW;
  localparam int PartW    = ProdW + dtp_pkg::INV_HALF_W;
  localparam int FullW    = ProdW + dtp_pkg::INV_W;
  localparam int QW       = FullW - dtp_pkg::FRAC_SHIFT;
  localparam int QExtW    = (QW > dtp_pkg::POS_W) ? QW : dtp_pkg::POS_W + 1;
  localparam int PosW     = dtp_pkg::POS_W;

  localparam logic [FullW-1:0] RoundBit = FullW'(1) << (dtp_pkg::FRAC_SHIFT - 1);
  localparam logic [QExtW-1:0] NegLimit = QExtW'(1) << (PosW - 1);
  localparam logic [QExtW-1:0] PosLimit = NegLimit - QExtW'(1);
  localparam logic [PosW-1:0]  SatNeg   = PosW'(1) << (PosW - 1);
  localparam logic [PosW-1:0]  SatPos   = SatNeg - PosW'(1);

  // Configuration registers.
  logic [dtp_pkg::DEPTH_W-1:0]  depth_floor;
  logic [dtp_pkg::DEPTH_W-1:0]  depth_ceil;
  logic [dtp_pkg::CENTER_W-1:0] center_x;
  logic [dtp_pkg::CENTER_W-1:0] center_y;
  logic [dtp_pkg::INV_W-1:0]    inv_focal_x;
  logic [dtp_pkg::INV_W-1:0]    inv_focal_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_floor <= dtp_pkg::DEPTH_FLOOR_RESET;
      depth_ceil  <= dtp_pkg::DEPTH_CEIL_RESET;
      center_x    <= dtp_pkg::CENTER_X_RESET;
      center_y    <= dtp_pkg::CENTER_Y_RESET;
      inv_focal_x <= dtp_pkg::INV_FOCAL_X_RESET;
      inv_focal_y <= dtp_pkg::INV_FOCAL_Y_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dtp_pkg::REG_DEPTH_FLOOR: depth_floor <= cfg_data[dtp_pkg::DEPTH_W-1:0];
        dtp_pkg::REG_DEPTH_CEIL:  depth_ceil  <= cfg_data[dtp_pkg::DEPTH_W-1:0];
        dtp_pkg::REG_CENTER_X:    center_x    <= cfg_data[dtp_pkg::CENTER_W-1:0];
        dtp_pkg::REG_CENTER_Y:    center_y    <= cfg_data[dtp_pkg::CENTER_W-1:0];
        dtp_pkg::REG_INV_FOCAL_X: inv_focal_x <= cfg_data[dtp_pkg::INV_W-1:0];
        dtp_pkg::REG_INV_FOCAL_Y: inv_focal_y <= cfg_data[dtp_pkg::INV_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = rst;

  logic accept;
  assign accept = start && !busy;

  // Input decode: range test and signed offsets from the principal point.
  logic [DepthUse-1:0] depth_in;
  logic [MagW-1:0]     pos_x_in;
  logic [MagW-1:0]     pos_y_in;
  logic [MagW-1:0]     cen_x_in;
  logic [MagW-1:0]     cen_y_in;
  logic                ok_in;
  logic                neg_x_in;
  logic                neg_y_in;
  logic [MagW-1:0]     mag_x_in;
  logic [MagW-1:0]     mag_y_in;

  always_comb begin
    depth_in = request.depth_mm[DepthUse-1:0];
    pos_x_in = MagW'({request.column[CoordUse-1:0], {dtp_pkg::SUBPIX_W{1'b0}}});
    pos_y_in = MagW'({request.row[CoordUse-1:0], {dtp_pkg::SUBPIX_W{1'b0}}});
    cen_x_in = MagW'(center_x);
    cen_y_in = MagW'(center_y);
    ok_in    = (depth_in != '0) &&
               (dtp_pkg::DEPTH_W'(depth_in) >= depth_floor) &&
               (dtp_pkg::DEPTH_W'(depth_in) <= depth_ceil);
    neg_x_in = pos_x_in < cen_x_in;
    neg_y_in = pos_y_in < cen_y_in;
    mag_x_in = neg_x_in ? (cen_x_in - pos_x_in) : (pos_x_in - cen_x_in);
    mag_y_in = neg_y_in ? (cen_y_in - pos_y_in) : (pos_y_in - cen_y_in);
  end

  // Stage valid bits.
  logic v1, v2, v3, v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= accept;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      done <= v4;
    end
  end

  // Payload registers of each stage.
  logic                ok1, ok2, ok3, ok4;
  logic                neg_x1, neg_x2, neg_x3, neg_x4;
  logic                neg_y1, neg_y2, neg_y3, neg_y4;
  logic [DepthUse-1:0] depth1, depth2, depth3, depth4;
  logic [MagW-1:0]     mag_x1, mag_y1;
  logic [ProdW-1:0]    prod_x2, prod_y2;
  logic [PartW-1:0]    lo_x3, hi_x3, lo_y3, hi_y3;
  logic [QW-1:0]       q_x4, q_y4;

  logic [FullW-1:0]    sum_x3, sum_y3;
  logic [QExtW-1:0]    qe_x4, qe_y4;
  logic [PosW-1:0]     x_sat, y_sat;

  always_comb begin
    sum_x3 = (FullW'(hi_x3) << dtp_pkg::INV_HALF_W) + FullW'(lo_x3) + RoundBit;
    sum_y3 = (FullW'(hi_y3) << dtp_pkg::INV_HALF_W) + FullW'(lo_y3) + RoundBit;
    qe_x4  = QExtW'(q_x4);
    qe_y4  = QExtW'(q_y4);
    if (neg_x4) begin
      x_sat = (qe_x4 >= NegLimit) ? SatNeg : (PosW'(0) - qe_x4[PosW-1:0]);
    end else begin
      x_sat = (qe_x4 > PosLimit) ? SatPos : qe_x4[PosW-1:0];
    end
    if (neg_y4) begin
      y_sat = (qe_y4 >= NegLimit) ? SatNeg : (PosW'(0) - qe_y4[PosW-1:0]);
    end else begin
      y_sat = (qe_y4 > PosLimit) ? SatPos : qe_y4[PosW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    // Stage 1: decoded request.
    ok1    <= ok_in;
    neg_x1 <= neg_x_in;
    neg_y1 <= neg_y_in;
    depth1 <= depth_in;
    mag_x1 <= mag_x_in;
    mag_y1 <= mag_y_in;
    // Stage 2: depth times offset.
    ok2     <= ok1;
    neg_x2  <= neg_x1;
    neg_y2  <= neg_y1;
    depth2  <= depth1;
    prod_x2 <= ProdW'(depth1) * ProdW'(mag_x1);
    prod_y2 <= ProdW'(depth1) * ProdW'(mag_y1);
    // Stage 3: the reciprocal is split into two halves to keep each multiplier narrow.
    ok3    <= ok2;
    neg_x3 <= neg_x2;
    neg_y3 <= neg_y2;
    depth3 <= depth2;
    lo_x3  <= PartW'(prod_x2) * PartW'(inv_focal_x[dtp_pkg::INV_HALF_W-1:0]);
    hi_x3  <= PartW'(prod_x2) * PartW'(inv_focal_x[dtp_pkg::INV_W-1:dtp_pkg::INV_HALF_W]);
    lo_y3  <= PartW'(prod_y2) * PartW'(inv_focal_y[dtp_pkg::INV_HALF_W-1:0]);
    hi_y3  <= PartW'(prod_y2) * PartW'(inv_focal_y[dtp_pkg::INV_W-1:dtp_pkg::INV_HALF_W]);
    // Stage 4: recombine, round half away from zero on the magnitude, drop the fraction.
    ok4    <= ok3;
    neg_x4 <= neg_x3;
    neg_y4 <= neg_y3;
    depth4 <= depth3;
    q_x4   <= sum_x3[FullW-1:dtp_pkg::FRAC_SHIFT];
    q_y4   <= sum_y3[FullW-1:dtp_pkg::FRAC_SHIFT];
    // Stage 5: saturate and apply the sign; an invalid pixel reports all zeros.
    result.point_valid <= ok4;
    result.x_pos       <= ok4 ? x_sat : '0;
    result.y_pos       <= ok4 ? y_sat : '0;
    result.z_pos       <= ok4 ? dtp_pkg::DEPTH_W'(depth4) : '0;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##5 done)
    else $error("accepted request did not produce a result five cycles later");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 5))
    else $error("result strobe without a matching request");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.point_valid |->
      result.x_pos == '0 && result.y_pos == '0 && result.z_pos == '0)
    else $error("invalid pixel reported nonzero coordinates");

  a_valid_range: assert property (@(posedge clk) disable iff (rst)
    done && result.point_valid |->
      result.z_pos != '0 && result.z_pos >= depth_floor && result.z_pos <= depth_ceil)
    else $error("valid point has depth outside the configured window");

endmodule

// ===== sim/dtp_point_checker.sv =====
// Checker that predicts each back-projected point and compares it with the block's output.
module dtp_point_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  dtp_pkg::request_t               request,
  input  logic                            done,
  input  dtp_pkg::result_t                result,
  input  logic                            cfg_write,
  input  logic [dtp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dtp_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              failures,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [dtp_pkg::DEPTH_W-1:0]  depth_lo;
  logic [dtp_pkg::DEPTH_W-1:0]  depth_hi;
  logic [dtp_pkg::CENTER_W-1:0] cx_sub;
  logic [dtp_pkg::CENTER_W-1:0] cy_sub;
  logic [dtp_pkg::INV_W-1:0]    inv_fx;
  logic [dtp_pkg::INV_W-1:0]    inv_fy;

  dtp_pkg::result_t expected_points[$];
  int               errs = 0;

  // Rounds half away from zero on the magnitude, then saturates to a signed 32-bit value.
  function automatic logic signed [dtp_pkg::POS_W-1:0] project_axis(
    input logic [dtp_pkg::DEPTH_W-1:0]  depth,
    input logic [dtp_pkg::COORD_W-1:0]  coord,
    input logic [dtp_pkg::CENTER_W-1:0] center,
    input logic [dtp_pkg::INV_W-1:0]    inv
  );
    logic [63:0] pos;
    logic [63:0] ctr;
    logic [63:0] mag;
    logic [63:0] prod;
    logic [63:0] q;
    logic        neg;
    pos  = {48'd0, coord, 4'd0};
    ctr  = {48'd0, center};
    neg  = pos < ctr;
    mag  = neg ? ctr - pos : pos - ctr;
    prod = {48'd0, depth} * mag * {40'd0, inv};
    q    = (prod + (64'd1 << (dtp_pkg::FRAC_SHIFT - 1))) >> dtp_pkg::FRAC_SHIFT;
    if (neg) begin
      if (q >= 64'h8000_0000) return 32'h8000_0000;
      return -q[dtp_pkg::POS_W-1:0];
    end
    if (q > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return q[dtp_pkg::POS_W-1:0];
  endfunction

  function automatic dtp_pkg::result_t backproject_pixel(input dtp_pkg::request_t px);
    dtp_pkg::result_t pt;
    pt = '0;
    if (px.depth_mm != '0 && px.depth_mm >= depth_lo && px.depth_mm <= depth_hi) begin
      pt.point_valid = 1'b1;
      pt.x_pos       = project_axis(px.depth_mm, px.column, cx_sub, inv_fx);
      pt.y_pos       = project_axis(px.depth_mm, px.row, cy_sub, inv_fy);
      pt.z_pos       = px.depth_mm;
    end
    return pt;
  endfunction

  always @(posedge clk) begin
    dtp_pkg::result_t want;
    if (rst) begin
      depth_lo = dtp_pkg::DEPTH_FLOOR_RESET;
      depth_hi = dtp_pkg::DEPTH_CEIL_RESET;
      cx_sub   = dtp_pkg::CENTER_X_RESET;
      cy_sub   = dtp_pkg::CENTER_Y_RESET;
      inv_fx   = dtp_pkg::INV_FOCAL_X_RESET;
      inv_fy   = dtp_pkg::INV_FOCAL_Y_RESET;
      expected_points.delete();
    end else begin
      if (done) begin
        if (expected_points.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("unexpected point: valid=%0d x=%0d y=%0d z=%0d",
                     result.point_valid, result.x_pos, result.y_pos, result.z_pos);
        end else begin
          want = expected_points.pop_front();
          if (result.point_valid !== want.point_valid || result.x_pos !== want.x_pos ||
              result.y_pos !== want.y_pos || result.z_pos !== want.z_pos) begin
            errs++;
            if (errs <= 10)
              $display("mismatch: exp v=%0d x=%0d y=%0d z=%0d got v=%0d x=%0d y=%0d z=%0d",
                       want.point_valid, want.x_pos, want.y_pos, want.z_pos,
                       result.point_valid, result.x_pos, result.y_pos, result.z_pos);
          end
        end
      end
      if (start && !busy)
        expected_points.push_back(backproject_pixel(request));
      // Writes to indexes outside the register list leave everything unchanged.
      if (cfg_write) begin
        case (cfg_index)
          dtp_pkg::REG_DEPTH_FLOOR: depth_lo = cfg_data[dtp_pkg::DEPTH_W-1:0];
          dtp_pkg::REG_DEPTH_CEIL:  depth_hi = cfg_data[dtp_pkg::DEPTH_W-1:0];
          dtp_pkg::REG_CENTER_X:    cx_sub   = cfg_data[dtp_pkg::CENTER_W-1:0];
          dtp_pkg::REG_CENTER_Y:    cy_sub   = cfg_data[dtp_pkg::CENTER_W-1:0];
          dtp_pkg::REG_INV_FOCAL_X: inv_fx   = cfg_data[dtp_pkg::INV_W-1:0];
          dtp_pkg::REG_INV_FOCAL_Y: inv_fy   = cfg_data[dtp_pkg::INV_W-1:0];
          default: ;
        endcase
      end
    end
    failures <= errs;
    pending  <= expected_points.size();
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top: drives depth pixels and register writes into the back-projector and reports.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [dtp_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [dtp_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

  logic                            clk;
  logic                            rst       = 1'b1;
  logic                            start     = 1'b0;
  logic                            busy;
  dtp_pkg::request_t               pixel     = '0;
  logic                            done;
  dtp_pkg::result_t                point;
  logic                            cfg_write = 1'b0;
  logic [dtp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [dtp_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

  int failures;
  int pending;
  int idle_pct = 20;

  logic [dtp_pkg::DEPTH_W-1:0] depth_lo = dtp_pkg::DEPTH_FLOOR_RESET;
  logic [dtp_pkg::DEPTH_W-1:0] depth_hi = dtp_pkg::DEPTH_CEIL_RESET;

  depth_to_point_backproject u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (pixel),
    .done      (done),
    .result    (point),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dtp_point_checker u_chk (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (pixel),
    .done      (done),
    .result    (point),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .failures  (failures),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #400_000;
    $display("FAIL");
    $finish;
  end

  // Entered and left at a falling edge; start is left high on return.
  task automatic send_pixel(input logic [dtp_pkg::DEPTH_W-1:0] depth,
                            input logic [dtp_pkg::COORD_W-1:0] col,
                            input logic [dtp_pkg::COORD_W-1:0] rw);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start          <= 1'b1;
    pixel.depth_mm <= depth;
    pixel.column   <= col;
    pixel.row      <= rw;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic program_regs(input logic [dtp_pkg::CFG_DATA_W-1:0] lo,
                              input logic [dtp_pkg::CFG_DATA_W-1:0] hi,
                              input logic [dtp_pkg::CFG_DATA_W-1:0] cx,
                              input logic [dtp_pkg::CFG_DATA_W-1:0] cy,
                              input logic [dtp_pkg::CFG_DATA_W-1:0] ifx,
                              input logic [dtp_pkg::CFG_DATA_W-1:0] ify);
    logic [dtp_pkg::CFG_DATA_W-1:0]  vals [8];
    logic [dtp_pkg::CFG_INDEX_W-1:0] idx  [8];
    vals = '{lo, hi, cx, cy, ifx, ify,
             dtp_pkg::CFG_DATA_W'($urandom), dtp_pkg::CFG_DATA_W'($urandom)};
    idx  = '{dtp_pkg::REG_DEPTH_FLOOR, dtp_pkg::REG_DEPTH_CEIL,
             dtp_pkg::REG_CENTER_X, dtp_pkg::REG_CENTER_Y,
             dtp_pkg::REG_INV_FOCAL_X, dtp_pkg::REG_INV_FOCAL_Y, REG_SPARE_A, REG_SPARE_B};
    cfg_write <= 1'b1;
    for (int i = 0; i < 8; i++) begin
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(negedge clk);
    end
    cfg_write <= 1'b0;
    depth_lo = lo[dtp_pkg::DEPTH_W-1:0];
    depth_hi = hi[dtp_pkg::DEPTH_W-1:0];
  endtask

  // Mostly depths inside the current window, so most requests produce real points.
  function automatic logic [dtp_pkg::DEPTH_W-1:0] rand_depth();
    int pick;
    pick = $urandom_range(99);
    if (depth_lo <= depth_hi && pick < 75)
      return dtp_pkg::DEPTH_W'($urandom_range(depth_hi, depth_lo));
    if (pick < 85) return '0;
    return dtp_pkg::DEPTH_W'($urandom);
  endfunction

  function automatic logic [dtp_pkg::COORD_W-1:0] rand_coord();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return dtp_pkg::COORD_W'($urandom_range(4095));
    endcase
  endfunction

  initial begin
    logic [dtp_pkg::CFG_DATA_W-1:0] lo, hi, ifx, ify;
    int waited;

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Reset window: zero depth, both window edges and just outside them.
    send_pixel(16'd0, 12'd0, 12'd0);
    send_pixel(16'd19, 12'd100, 12'd100);
    send_pixel(16'd20, 12'd0, 12'd0);
    send_pixel(16'd4000, 12'd4095, 12'd4095);
    send_pixel(16'd4001, 12'd300, 12'd200);
    send_pixel(16'd65535, 12'd4095, 12'd4095);
    send_pixel(16'd1000, 12'd308, 12'd250);
    drain();

    // Widest window and largest reciprocals push both coordinates into saturation.
    program_regs(24'd0, 24'd65535, 24'd0, 24'd65535, 24'hFF_FFFF, 24'hFF_FFFF);
    send_pixel(16'd0, 12'd4095, 12'd0);
    send_pixel(16'd65535, 12'd4095, 12'd0);
    send_pixel(16'd1, 12'd0, 12'd4095);
    send_pixel(16'd32768, 12'd2048, 12'd2048);
    drain();

    program_regs(24'd0, 24'd65535, 24'd65535, 24'd0, 24'hFF_FFFF, 24'hFF_FFFF);
    send_pixel(16'd65535, 12'd0, 12'd4095);
    send_pixel(16'd65535, 12'd4095, 12'd0);
    drain();

    // A reciprocal of one half with odd offsets lands exactly on rounding halves.
    program_regs(24'd1, 24'd65535, 24'd17, 24'd17, 24'h80_0000, 24'h80_0000);
    send_pixel(16'd1, 12'd0, 12'd2);
    send_pixel(16'd1, 12'd2, 12'd0);
    send_pixel(16'd3, 12'd1, 12'd1);
    send_pixel(16'd65535, 12'd1, 12'd4095);
    drain();

    // Minimum above maximum rejects every depth.
    program_regs(24'd5000, 24'd100, 24'd4938, 24'd4011, 24'd29313, 24'd29096);
    send_pixel(16'd100, 12'd10, 12'd10);
    send_pixel(16'd5000, 12'd10, 12'd10);
    send_pixel(16'd3000, 12'd10, 12'd10);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case ($urandom_range(9))
        0: begin lo = 24'd0; hi = 24'd65535; end
        1: begin lo = dtp_pkg::CFG_DATA_W'($urandom_range(65535)); hi = lo; end
        2: begin
          lo = dtp_pkg::CFG_DATA_W'($urandom_range(65535, 20000));
          hi = dtp_pkg::CFG_DATA_W'($urandom_range(19999));
        end
        default: begin
          lo = dtp_pkg::CFG_DATA_W'($urandom_range(3000));
          hi = dtp_pkg::CFG_DATA_W'($urandom_range(65535, lo));
        end
      endcase
      case ($urandom_range(7))
        0:       ifx = '0;
        1:       ifx = 24'hFF_FFFF;
        2:       ifx = dtp_pkg::CFG_DATA_W'($urandom);
        default: ifx = dtp_pkg::CFG_DATA_W'($urandom_range(200000, 1000));
      endcase
      case ($urandom_range(7))
        0:       ify = '0;
        1:       ify = 24'hFF_FFFF;
        2:       ify = dtp_pkg::CFG_DATA_W'($urandom);
        default: ify = dtp_pkg::CFG_DATA_W'($urandom_range(200000, 1000));
      endcase
      // High data bits above a 16-bit register must be dropped by the block.
      program_regs({8'($urandom), lo[15:0]}, {8'($urandom), hi[15:0]},
                   dtp_pkg::CFG_DATA_W'($urandom), dtp_pkg::CFG_DATA_W'($urandom), ifx, ify);
      idle_pct = (ph == 1) ? 0 : 20;
      for (int i = 0; i < 90; i++) begin
        if (ph == 3 && i == 45) drain();
        send_pixel(rand_depth(), rand_coord(), rand_coord());
      end
      drain();
    end

    waited = 0;
    while (pending != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (failures == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
